/* design/dqpi_pkg.sv */
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared types, constants and saturation and sign helpers of the dq current controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

  localparam int DATA_W = 32;
  localparam int GAIN_W = 31;
  localparam int ERR_W  = 33;
  localparam int OPB_W  = 32;
  localparam int PROD_W = ERR_W + OPB_W;
  localparam int SUM_W  = 34;
  localparam int ACC_W  = 52;
  localparam int SGN_W  = ACC_W + 1;
  localparam int WIDE_W = ACC_W + 2;

  localparam logic [OPB_W-1:0] SAMPLE_PERIOD_Q31 = 32'd214748;
  localparam int OUTPUT_SIGN = 1;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 54'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -54'sd2147483648;

  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_PRELOAD = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_KP_D        = 3'd0,
    REG_KI_D        = 3'd1,
    REG_KP_Q        = 3'd2,
    REG_KI_Q        = 3'd3,
    REG_INTEG_UPPER = 3'd4,
    REG_INTEG_LOWER = 3'd5,
    REG_RESISTANCE  = 3'd6,
    REG_REACTANCE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        kp_d;
    logic [GAIN_W-1:0]        ki_d;
    logic [GAIN_W-1:0]        kp_q;
    logic [GAIN_W-1:0]        ki_q;
    logic signed [DATA_W-1:0] integ_upper;
    logic signed [DATA_W-1:0] integ_lower;
    logic signed [DATA_W-1:0] resistance;
    logic signed [DATA_W-1:0] reactance;
  } cfg_t;

  typedef struct packed {
    mode_e                    mode;
    logic signed [DATA_W-1:0] cur_ref_d;
    logic signed [DATA_W-1:0] cur_ref_q;
    logic signed [DATA_W-1:0] cur_meas_d;
    logic signed [DATA_W-1:0] cur_meas_q;
    logic signed [DATA_W-1:0] grid_volt_d;
    logic signed [DATA_W-1:0] grid_volt_q;
    logic signed [DATA_W-1:0] preset_d;
    logic signed [DATA_W-1:0] preset_q;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] feedfwd_q;
    logic signed [DATA_W-1:0] feedback_q;
    logic signed [DATA_W-1:0] feedfwd_d;
    logic signed [DATA_W-1:0] feedback_d;
    logic signed [DATA_W-1:0] volt_out_q;
    logic signed [DATA_W-1:0] volt_out_d;
  } result_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SGN_W-1:0] apply_sign(input logic signed [ACC_W-1:0] v);
    logic signed [SGN_W-1:0] ext;
    logic signed [SGN_W-1:0] r;
    ext = {v[ACC_W-1], v};
    if (OUTPUT_SIGN > 0) begin
      r = ext;
    end else if (OUTPUT_SIGN < 0) begin
      r = -ext;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

/* design/dqpi_mul.sv */
// ----------------------------------------------------------------------------
// dqpi_mul
// Shared signed 33 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module dqpi_mul (
  input  logic                                  clk_i,
  input  logic signed [dqpi_pkg::ERR_W-1:0]     a_i,
  input  logic signed [dqpi_pkg::OPB_W-1:0]     b_i,
  output logic signed [dqpi_pkg::PROD_W-1:0]    p_o
);
  import dqpi_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

/* design/dqpi_core.sv */
// ----------------------------------------------------------------------------
// dqpi_core
// Sequencer and datapath: steps both axes through the shared multiplier.
// ----------------------------------------------------------------------------
module dqpi_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqpi_pkg::cfg_t    cfg_i,
  input  logic              start_i,
  input  dqpi_pkg::item_t   item_i,
  output logic              ready_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  output dqpi_pkg::result_t res_o
);
  import dqpi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC_MUL,
    ST_INC_ADD,
    ST_CLAMP,
    ST_KI_MUL,
    ST_KI_ACC,
    ST_FB,
    ST_X_ACC,
    ST_FF,
    ST_OUT,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic                     axis_q;
  logic signed [DATA_W-1:0] integ_q [2];
  logic signed [DATA_W-1:0] fb_q    [2];
  logic signed [DATA_W-1:0] ff_q    [2];
  logic signed [DATA_W-1:0] hout_q  [2];

  logic signed [ERR_W-1:0]  err_q   [2];
  logic signed [DATA_W-1:0] meas_q  [2];
  logic signed [DATA_W-1:0] vg_q    [2];
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic                     oth;
  logic [GAIN_W-1:0]        kp_sel;
  logic [GAIN_W-1:0]        ki_sel;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_s31;
  logic signed [PROD_W-1:0] prod_s16;
  logic signed [ACC_W-1:0]  term16;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  up34;
  logic signed [SUM_W-1:0]  lo34;
  logic signed [SUM_W-1:0]  clamped;
  logic signed [ACC_W-1:0]  acc_x;
  logic signed [SGN_W-1:0]  acc_sgn;
  logic signed [DATA_W-1:0] fb_val;
  logic signed [DATA_W-1:0] ff_val;
  logic signed [DATA_W-1:0] hout_val [2];
  logic signed [DATA_W-1:0] pre_val  [2];

  assign oth    = ~axis_q;
  assign kp_sel = axis_q ? cfg_i.kp_q : cfg_i.kp_d;
  assign ki_sel = axis_q ? cfg_i.ki_q : cfg_i.ki_d;

  always_comb begin
    unique case (state_q)
      ST_INC_MUL: begin
        mul_a = err_q[axis_q];
        mul_b = SAMPLE_PERIOD_Q31;
      end
      ST_INC_ADD: begin
        mul_a = err_q[axis_q];
        mul_b = {1'b0, kp_sel};
      end
      ST_KI_MUL: begin
        mul_a = {integ_q[axis_q][DATA_W-1], integ_q[axis_q]};
        mul_b = {1'b0, ki_sel};
      end
      ST_KI_ACC: begin
        mul_a = {meas_q[axis_q][DATA_W-1], meas_q[axis_q]};
        mul_b = cfg_i.resistance;
      end
      ST_FB: begin
        mul_a = {meas_q[oth][DATA_W-1], meas_q[oth]};
        mul_b = cfg_i.reactance;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dqpi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_s31 = prod >>> 31;
  assign prod_s16 = prod >>> 16;
  assign term16   = prod_s16[ACC_W-1:0];
  assign sum_d    = {{(SUM_W-DATA_W){integ_q[axis_q][DATA_W-1]}}, integ_q[axis_q]}
                  + prod_s31[SUM_W-1:0];
  assign up34     = {{(SUM_W-DATA_W){cfg_i.integ_upper[DATA_W-1]}}, cfg_i.integ_upper};
  assign lo34     = {{(SUM_W-DATA_W){cfg_i.integ_lower[DATA_W-1]}}, cfg_i.integ_lower};
  assign acc_x    = axis_q ? (acc_q + term16) : (acc_q - term16);
  assign acc_sgn  = apply_sign(acc_q);
  assign fb_val   = sat32({acc_sgn[SGN_W-1], acc_sgn});
  assign ff_val   = sat32({acc_sgn[SGN_W-1], acc_sgn}
                  + {{(WIDE_W-DATA_W){vg_q[axis_q][DATA_W-1]}}, vg_q[axis_q]});

  always_comb begin
    clamped = sum_q;
    if (clamped > up34) begin
      clamped = up34;
    end
    if (clamped < lo34) begin
      clamped = lo34;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hout_val[i] = sat32({{(WIDE_W-DATA_W){fb_q[i][DATA_W-1]}}, fb_q[i]}
                  + {{(WIDE_W-DATA_W){ff_q[i][DATA_W-1]}}, ff_q[i]});
    end
  end

  always_comb begin
    pre_val[0] = item_i.preset_d;
    pre_val[1] = item_i.preset_q;
    for (int i = 0; i < 2; i++) begin
      if (pre_val[i] > cfg_i.integ_upper) begin
        pre_val[i] = cfg_i.integ_upper;
      end else if (pre_val[i] < cfg_i.integ_lower) begin
        pre_val[i] = cfg_i.integ_lower;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        integ_q[i] <= '0;
        fb_q[i]    <= '0;
        ff_q[i]    <= '0;
        hout_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            unique case (item_i.mode)
              MODE_UPDATE: begin
                axis_q  <= 1'b0;
                state_q <= ST_INC_MUL;
              end
              MODE_CLEAR: begin
                integ_q[0] <= '0;
                integ_q[1] <= '0;
                hout_q[0]  <= '0;
                hout_q[1]  <= '0;
                state_q    <= ST_DONE;
              end
              MODE_PRELOAD: begin
                integ_q[0] <= pre_val[0];
                integ_q[1] <= pre_val[1];
                state_q    <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_INC_MUL: state_q <= ST_INC_ADD;
        ST_INC_ADD: state_q <= ST_CLAMP;
        ST_CLAMP: begin
          integ_q[axis_q] <= clamped[DATA_W-1:0];
          state_q         <= ST_KI_MUL;
        end
        ST_KI_MUL: state_q <= ST_KI_ACC;
        ST_KI_ACC: state_q <= ST_FB;
        ST_FB: begin
          fb_q[axis_q] <= fb_val;
          state_q      <= ST_X_ACC;
        end
        ST_X_ACC: state_q <= ST_FF;
        ST_FF: begin
          ff_q[axis_q] <= ff_val;
          if (axis_q) begin
            state_q <= ST_OUT;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_INC_MUL;
          end
        end
        ST_OUT: begin
          hout_q[0] <= hout_val[0];
          hout_q[1] <= hout_val[1];
          state_q   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          err_q[0]  <= {item_i.cur_ref_d[DATA_W-1], item_i.cur_ref_d}
                     - {item_i.cur_meas_d[DATA_W-1], item_i.cur_meas_d};
          err_q[1]  <= {item_i.cur_ref_q[DATA_W-1], item_i.cur_ref_q}
                     - {item_i.cur_meas_q[DATA_W-1], item_i.cur_meas_q};
          meas_q[0] <= item_i.cur_meas_d;
          meas_q[1] <= item_i.cur_meas_q;
          vg_q[0]   <= item_i.grid_volt_d;
          vg_q[1]   <= item_i.grid_volt_q;
        end
      end
      ST_INC_ADD: sum_q <= sum_d;
      ST_CLAMP:   acc_q <= term16;
      ST_KI_ACC:  acc_q <= acc_q + term16;
      ST_FB:      acc_q <= term16;
      ST_X_ACC:   acc_q <= acc_x;
      default: ;
    endcase
  end

  assign ready_o    = (state_q == ST_IDLE);
  assign out_load_o = (state_q == ST_DONE) && out_free_i;

  assign res_o.volt_out_d = hout_q[0];
  assign res_o.volt_out_q = hout_q[1];
  assign res_o.feedback_d = fb_q[0];
  assign res_o.feedfwd_d  = ff_q[0];
  assign res_o.feedback_q = fb_q[1];
  assign res_o.feedfwd_q  = ff_q[1];

endmodule

/* design/dq_current_pi_controller.sv */
// ----------------------------------------------------------------------------
// dq_current_pi_controller
// Two-axis dq PI current controller with decoupling feedforward.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one item: references, measured currents, grid
//   voltages and integrator presets in tdata, the mode in tuser.
//   The m_axis channel returns one item per input item: voltage commands and
//   their feedback and feedforward parts.
//   The cfg channel writes gains, integrator limits, R and reactance; it is
//   always ready, and must be written only while no item is in flight: the
//   block itself does not enforce this. In a control update each axis takes
//   eight steps through the one shared 33 x 32 multiplier, then the OUT state
//   forms the commands and the DONE state loads the output register. Clear,
//   preload and hold items go from IDLE straight to DONE. s_axis_tready is
//   high only while the sequencer is idle, so one item is in flight at a
//   time.
//   A finished result sits in the output register; the next item is taken
//   while it waits, but its result holds in the core until m_axis_tready
//   frees the register.
//   Reset clears the integrators and held outputs and loads the default
//   configuration (integrator limits +/-400.0, all else zero).
// ----------------------------------------------------------------------------
module dq_current_pi_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cur_ref_d, cur_ref_q, cur_meas_d, cur_meas_q, grid_volt_d, grid_volt_q,
  // preset_d, preset_q
  input  logic [255:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // volt_out_d, volt_out_q, feedback_d, feedfwd_d, feedback_q, feedfwd_q
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import dqpi_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  result_t res;
  logic    core_ready;
  logic    out_load;
  logic    out_free;
  logic    m_valid_q;
  result_t m_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_d        <= '0;
      cfg_q.ki_d        <= '0;
      cfg_q.kp_q        <= '0;
      cfg_q.ki_q        <= '0;
      cfg_q.integ_upper <= 32'sd26214400;
      cfg_q.integ_lower <= -32'sd26214400;
      cfg_q.resistance  <= '0;
      cfg_q.reactance   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_KP_D:        cfg_q.kp_d        <= cfg_data_i[GAIN_W-1:0];
        REG_KI_D:        cfg_q.ki_d        <= cfg_data_i[GAIN_W-1:0];
        REG_KP_Q:        cfg_q.kp_q        <= cfg_data_i[GAIN_W-1:0];
        REG_KI_Q:        cfg_q.ki_q        <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_UPPER: cfg_q.integ_upper <= cfg_data_i;
        REG_INTEG_LOWER: cfg_q.integ_lower <= cfg_data_i;
        REG_RESISTANCE:  cfg_q.resistance  <= cfg_data_i;
        REG_REACTANCE:   cfg_q.reactance   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.mode        = mode_e'(s_axis_tuser);
  assign item.cur_ref_d   = s_axis_tdata[31:0];
  assign item.cur_ref_q   = s_axis_tdata[63:32];
  assign item.cur_meas_d  = s_axis_tdata[95:64];
  assign item.cur_meas_q  = s_axis_tdata[127:96];
  assign item.grid_volt_d = s_axis_tdata[159:128];
  assign item.grid_volt_q = s_axis_tdata[191:160];
  assign item.preset_d    = s_axis_tdata[223:192];
  assign item.preset_q    = s_axis_tdata[255:224];

  assign s_axis_tready = core_ready;
  assign out_free      = !m_valid_q || m_axis_tready;

  dqpi_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (s_axis_tvalid && core_ready),
    .item_i     (item),
    .ready_o    (core_ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* bench/tb_dq_current_pi_controller.sv */
// ----------------------------------------------------------------------------
// tb_dq_current_pi_controller
// Self-checking bench for the dq current controller. A bit-exact predictor
// tracks the integrators and held commands and checks every output item in
// order. Directed items cover field extremes, every mode and the clamp cases.
// Random traffic then runs over several register settings and idle patterns,
// including a long output hold-off that backs the input up.
// ----------------------------------------------------------------------------
module tb_dq_current_pi_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import dqpi_pkg::*;

  localparam logic [1:0] MODE_HOLD = 2'd3;
  localparam int N_REGS = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_SETTINGS = 5;
  localparam int ITEMS_PER_SETTING = 52;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  dq_current_pi_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  longint gain_kp_d, gain_ki_d, gain_kp_q, gain_ki_q;
  longint lim_upper, lim_lower, filt_r, filt_x;
  longint integ_d, integ_q;
  result_t held_cmd;

  result_t pending_cmds [$];
  logic [31:0] setting [N_REGS];
  string field_name [6] = '{"volt_out_d", "volt_out_q", "feedback_d",
                            "feedfwd_d", "feedback_q", "feedfwd_q"};

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat_q16(longint v);
    if (v > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
    if (v < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
    return v;
  endfunction

  function automatic longint preset_clamp(longint v);
    if (v > lim_upper) return lim_upper;
    if (v < lim_lower) return lim_lower;
    return v;
  endfunction

  function automatic void note_config(cfg_idx_e idx, logic [31:0] data);
    case (idx)
      REG_KP_D:        gain_kp_d = longint'({1'b0, data[30:0]});
      REG_KI_D:        gain_ki_d = longint'({1'b0, data[30:0]});
      REG_KP_Q:        gain_kp_q = longint'({1'b0, data[30:0]});
      REG_KI_Q:        gain_ki_q = longint'({1'b0, data[30:0]});
      REG_INTEG_UPPER: lim_upper = longint'(signed'(data));
      REG_INTEG_LOWER: lim_lower = longint'(signed'(data));
      REG_RESISTANCE:  filt_r = longint'(signed'(data));
      REG_REACTANCE:   filt_x = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    gain_kp_d = 0;
    gain_ki_d = 0;
    gain_kp_q = 0;
    gain_ki_q = 0;
    lim_upper = 26214400;
    lim_lower = -26214400;
    filt_r = 0;
    filt_x = 0;
    integ_d = 0;
    integ_q = 0;
    held_cmd = '0;
  endfunction

  function automatic void pi_axis(input longint cur_ref, cur_meas, cross_meas, grid_v,
                                  input longint kp, ki, cross_sign,
                                  inout longint integ, output longint fb, ff);
    longint err, inc, pi, dec;
    err = cur_ref - cur_meas;
    inc = (err * longint'(SAMPLE_PERIOD_Q31)) >>> 31;
    integ = integ + inc;
    if (integ > lim_upper) integ = lim_upper;
    if (integ < lim_lower) integ = lim_lower;
    pi = ((kp * err) >>> 16) + ((ki * integ) >>> 16);
    fb = sat_q16(pi * OUTPUT_SIGN);
    dec = ((filt_r * cur_meas) >>> 16) + cross_sign * ((filt_x * cross_meas) >>> 16);
    ff = sat_q16(dec * OUTPUT_SIGN + grid_v);
  endfunction

  function automatic result_t predict_command(item_t it);
    longint fbd, ffd, fbq, ffq, cmd;
    case (it.mode)
      MODE_UPDATE: begin
        pi_axis(it.cur_ref_d, it.cur_meas_d, it.cur_meas_q, it.grid_volt_d,
                gain_kp_d, gain_ki_d, -1, integ_d, fbd, ffd);
        pi_axis(it.cur_ref_q, it.cur_meas_q, it.cur_meas_d, it.grid_volt_q,
                gain_kp_q, gain_ki_q, 1, integ_q, fbq, ffq);
        held_cmd.feedback_d = fbd[31:0];
        held_cmd.feedfwd_d  = ffd[31:0];
        held_cmd.feedback_q = fbq[31:0];
        held_cmd.feedfwd_q  = ffq[31:0];
        cmd = sat_q16(fbd + ffd);
        held_cmd.volt_out_d = cmd[31:0];
        cmd = sat_q16(fbq + ffq);
        held_cmd.volt_out_q = cmd[31:0];
      end
      MODE_CLEAR: begin
        integ_d = 0;
        integ_q = 0;
        held_cmd.volt_out_d = '0;
        held_cmd.volt_out_q = '0;
      end
      MODE_PRELOAD: begin
        integ_d = preset_clamp(it.preset_d);
        integ_q = preset_clamp(it.preset_q);
      end
      default: ;
    endcase
    return held_cmd;
  endfunction

  function automatic item_t make_item(logic [1:0] mode, logic [31:0] ref_d, ref_q,
                                      logic [31:0] meas_d, meas_q, vg_d, vg_q,
                                      logic [31:0] pre_d, pre_q);
    item_t it;
    it.mode        = mode_e'(mode);
    it.cur_ref_d   = ref_d;
    it.cur_ref_q   = ref_q;
    it.cur_meas_d  = meas_d;
    it.cur_meas_q  = meas_q;
    it.grid_volt_d = vg_d;
    it.grid_volt_q = vg_q;
    it.preset_d    = pre_d;
    it.preset_q    = pre_q;
    return it;
  endfunction

  function automatic logic [31:0] draw_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1, 2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      4: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] draw_gain();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000);
      2: return $urandom_range(0, 32'h0200_0000);
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic void max_settings();
    setting[REG_KP_D]        = 32'hffff_ffff;
    setting[REG_KI_D]        = 32'hffff_ffff;
    setting[REG_KP_Q]        = 32'hffff_ffff;
    setting[REG_KI_Q]        = 32'hffff_ffff;
    setting[REG_INTEG_UPPER] = 32'h7fff_ffff;
    setting[REG_INTEG_LOWER] = 32'h8000_0000;
    setting[REG_RESISTANCE]  = 32'h7fff_ffff;
    setting[REG_REACTANCE]   = 32'h7fff_ffff;
  endfunction

  function automatic void min_settings();
    setting[REG_KP_D]        = 32'h0000_0000;
    setting[REG_KI_D]        = 32'h0000_0000;
    setting[REG_KP_Q]        = 32'h0000_0000;
    setting[REG_KI_Q]        = 32'h0000_0000;
    setting[REG_INTEG_UPPER] = 32'h8000_0000;
    setting[REG_INTEG_LOWER] = 32'h7fff_ffff;
    setting[REG_RESISTANCE]  = 32'h8000_0000;
    setting[REG_REACTANCE]   = 32'h8000_0000;
  endfunction

  function automatic void draw_settings();
    logic [31:0] span;
    case ($urandom_range(5))
      0: max_settings();
      1: min_settings();
      default: begin
        setting[REG_KP_D] = draw_gain();
        setting[REG_KI_D] = draw_gain();
        setting[REG_KP_Q] = draw_gain();
        setting[REG_KI_Q] = draw_gain();
        case ($urandom_range(4))
          0, 1: begin
            span = $urandom_range(1, 32'h0400_0000);
            setting[REG_INTEG_UPPER] = span;
            setting[REG_INTEG_LOWER] = -span;
          end
          2: begin
            setting[REG_INTEG_UPPER] = $urandom;
            setting[REG_INTEG_LOWER] = $urandom;
          end
          3: begin
            setting[REG_INTEG_UPPER] = 32'h7fff_ffff;
            setting[REG_INTEG_LOWER] = 32'h8000_0000;
          end
          default: begin
            setting[REG_INTEG_UPPER] = $urandom_range(0, 32'h0100_0000);
            setting[REG_INTEG_LOWER] = -$urandom_range(0, 32'h0200_0000);
          end
        endcase
        setting[REG_RESISTANCE] = draw_q16();
        setting[REG_REACTANCE]  = draw_q16();
      end
    endcase
  endfunction

  function automatic item_t draw_item();
    int pick;
    logic [1:0] mode;
    pick = $urandom_range(99);
    if (pick < 82) mode = MODE_UPDATE;
    else if (pick < 89) mode = MODE_CLEAR;
    else if (pick < 95) mode = MODE_PRELOAD;
    else mode = MODE_HOLD;
    return make_item(mode, draw_q16(), draw_q16(), draw_q16(), draw_q16(),
                     draw_q16(), draw_q16(), draw_q16(), draw_q16());
  endfunction

  task automatic set_idling(int gap, int stall);
    send_gap_pct <= gap;
    recv_stall_pct <= stall;
  endtask

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {it.preset_q, it.preset_d, it.grid_volt_q, it.grid_volt_d,
                      it.cur_meas_q, it.cur_meas_d, it.cur_ref_q, it.cur_ref_d};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cmds.push_back(predict_command(it));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cmds.size() != 0);
  endtask

  task automatic apply_settings();
    for (int i = 0; i < N_REGS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i  <= setting[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      note_config(cfg_idx_e'(i), setting[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(MODE_UPDATE, 32'h0, 32'h0, 32'h0001_0000, 32'hfffe_0000,
                        32'h0140_0000, 32'hfec0_0000, 32'h0, 32'h0));
    send_item(make_item(MODE_HOLD, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom));
    send_item(make_item(MODE_PRELOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(MODE_UPDATE, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'h0, 32'h0, 32'h0));
    drain_results();
  endtask

  task automatic test_field_extremes();
    max_settings();
    apply_settings();
    send_item(make_item(MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0));
    send_item(make_item(MODE_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0));
    send_item(make_item(MODE_UPDATE, '1, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_item(MODE_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_item(MODE_HOLD, '1, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_item(MODE_PRELOAD, '1, '1, '1, '1, '1, '1, 32'h7fff_ffff,
                        32'h8000_0000));
    send_item(make_item(MODE_UPDATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'h0));
    drain_results();
    min_settings();
    apply_settings();
    send_item(make_item(MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_item(make_item(MODE_PRELOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h7fff_ffff, 32'h0000_1000));
    send_item(make_item(MODE_UPDATE, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0));
    drain_results();
  endtask

  task automatic test_crossed_limits();
    setting[REG_KP_D]        = 32'h0001_0000;
    setting[REG_KI_D]        = 32'h0001_0000;
    setting[REG_KP_Q]        = 32'h0001_0000;
    setting[REG_KI_Q]        = 32'h0001_0000;
    setting[REG_INTEG_UPPER] = 32'hff9c_0000;
    setting[REG_INTEG_LOWER] = 32'h0064_0000;
    setting[REG_RESISTANCE]  = 32'h0000_8000;
    setting[REG_REACTANCE]   = 32'h0002_0000;
    apply_settings();
    send_item(make_item(MODE_PRELOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'hff38_0000));
    send_item(make_item(MODE_UPDATE, 32'h0001_0000, 32'hffff_0000, 32'h0,
                        32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0));
    send_item(make_item(MODE_PRELOAD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(MODE_UPDATE, 32'h0, 32'h0, 32'h0001_8000, 32'hfffe_0000,
                        32'h0010_0000, 32'h0, 32'h0, 32'h0));
    drain_results();
  endtask

  task automatic test_integrator_clamp();
    setting[REG_KP_D]        = 32'h0002_0000;
    setting[REG_KI_D]        = 32'h0064_0000;
    setting[REG_KP_Q]        = 32'h0002_0000;
    setting[REG_KI_Q]        = 32'h0064_0000;
    setting[REG_INTEG_UPPER] = 32'h0001_0000;
    setting[REG_INTEG_LOWER] = 32'hffff_0000;
    setting[REG_RESISTANCE]  = 32'h0000_4000;
    setting[REG_REACTANCE]   = 32'h0003_0000;
    apply_settings();
    repeat (2) begin
      send_item(make_item(MODE_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                          32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    end
    repeat (2) begin
      send_item(make_item(MODE_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0));
    end
    send_item(make_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h0, 32'h0));
    send_item(make_item(MODE_UPDATE, 32'h0000_8000, 32'hffff_8000, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0));
    drain_results();
  endtask

  task automatic test_random_traffic(int gap, int stall);
    set_idling(gap, stall);
    for (int s = 0; s < N_SETTINGS; s++) begin
      draw_settings();
      apply_settings();
      repeat (ITEMS_PER_SETTING) send_item(draw_item());
      drain_results();
    end
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    draw_settings();
    apply_settings();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    repeat (24) send_item(draw_item());
    drain_results();
    repeat (8) send_item(draw_item());
    drain_results();
    set_idling(28, 28);
    repeat (8) send_item(draw_item());
    drain_results();
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    logic [191:0] want_bits;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected item", '0, m_axis_tdata[31:0]);
      end else begin
        want = pending_cmds.pop_front();
        want_bits = want;
        for (int i = 0; i < 6; i++) begin
          if (m_axis_tdata[32*i +: 32] !== want_bits[32*i +: 32]) begin
            report_mismatch(field_name[i], want_bits[32*i +: 32], m_axis_tdata[32*i +: 32]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_crossed_limits();
    test_integrator_clamp();
    test_random_traffic(0, 0);
    test_random_traffic(63, 0);
    test_random_traffic(0, 63);
    test_random_traffic(28, 28);
    test_output_backpressure();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
